[design/tlpc_pkg.sv]
// Shared types, codes and tables for the traffic light phase controller.
// No dependencies; used by tlpc_cfg_regs, tlpc_step and the top level.
package tlpc_pkg;

    localparam int DWELL_W   = 16;
    localparam int SENSOR_W  = 7;
    localparam int NUM_LIGHT = 7;
    localparam int CFG_IDX_W = 2;

    // Reset values of the dwell registers
    localparam logic [DWELL_W-1:0] GREEN_DWELL_RST  = 16'd5;
    localparam logic [DWELL_W-1:0] YELLOW_DWELL_RST = 16'd1;
    localparam logic [DWELL_W-1:0] RED_DWELL_RST    = 16'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GREEN_DWELL  = 2'd0,
        CFG_YELLOW_DWELL = 2'd1,
        CFG_RED_DWELL    = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_S1   = 4'd0,
        PH_S2   = 4'd1,
        PH_S3   = 4'd2,
        PH_S4   = 4'd3,
        PH_S5   = 4'd4,
        PH_S5B  = 4'd5,
        PH_S6   = 4'd6,
        PH_S6B  = 4'd7,
        PH_S7   = 4'd8,
        PH_S8   = 4'd9,
        PH_S8B  = 4'd10,
        PH_S9   = 4'd11,
        PH_S9B  = 4'd12,
        PH_S10  = 4'd13,
        PH_S11  = 4'd14,
        PH_S12  = 4'd15
    } phase_t;

    // Which dwell register reloads the counter
    typedef enum logic [1:0] {
        SEL_RED    = 2'd0,
        SEL_YELLOW = 2'd1,
        SEL_GREEN  = 2'd2
    } dwell_sel_t;

    typedef enum logic [1:0] {
        C_RED    = 2'd0,
        C_YELLOW = 2'd1,
        C_GREEN  = 2'd2
    } colour_t;

    // Element k is signal k+1
    typedef colour_t [NUM_LIGHT-1:0] colours_t;

    typedef struct packed {
        logic [DWELL_W-1:0] green;
        logic [DWELL_W-1:0] yellow;
        logic [DWELL_W-1:0] red;
    } dwell_cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [DWELL_W-1:0] dwell;
        logic               changed;
        colours_t           colours;
    } step_res_t;

    // Sensor masks, bit k-1 is sensor k
    localparam logic [SENSOR_W-1:0] MASK_S1_GO  = 7'b1100000; // sensors 6,7
    localparam logic [SENSOR_W-1:0] MASK_S5_GO  = 7'b0111101; // 1,3,4,5,6
    localparam logic [SENSOR_W-1:0] MASK_S9_GO  = 7'b1100110; // 2,3,6,7
    localparam logic [SENSOR_W-1:0] MASK_S9B_GO = 7'b1100111; // 1,2,3,6,7
    localparam logic [SENSOR_W-1:0] MASK_S12_GO = 7'b1101011; // 1,2,4,6,7

    // Signal colours shown in each phase; argument order is signal 1..7
    function automatic colours_t mk(colour_t a, colour_t b, colour_t c, colour_t d,
                                    colour_t e, colour_t f, colour_t g);
        colours_t r;
        r = {g, f, e, d, c, b, a};
        return r;
    endfunction

    function automatic colours_t phase_colours(phase_t ph);
        colours_t r;
        unique case (ph)
            PH_S1:   r = mk(C_RED,    C_RED,    C_RED,   C_RED,    C_RED,    C_RED,    C_RED);
            PH_S2:   r = mk(C_RED,    C_RED,    C_RED,   C_RED,    C_RED,    C_GREEN,  C_GREEN);
            PH_S3:   r = mk(C_RED,    C_RED,    C_RED,   C_RED,    C_RED,    C_YELLOW, C_GREEN);
            PH_S4:   r = mk(C_RED,    C_RED,    C_RED,   C_RED,    C_RED,    C_RED,    C_GREEN);
            PH_S5:   r = mk(C_GREEN,  C_GREEN,  C_RED,   C_RED,    C_RED,    C_RED,    C_GREEN);
            PH_S5B:  r = mk(C_RED,    C_GREEN,  C_RED,   C_RED,    C_RED,    C_RED,    C_GREEN);
            PH_S6:   r = mk(C_YELLOW, C_YELLOW, C_RED,   C_RED,    C_RED,    C_RED,    C_YELLOW);
            PH_S6B:  r = mk(C_RED,    C_YELLOW, C_RED,   C_RED,    C_RED,    C_RED,    C_YELLOW);
            PH_S7:   r = mk(C_RED,    C_RED,    C_RED,   C_RED,    C_RED,    C_RED,    C_RED);
            PH_S8:   r = mk(C_GREEN,  C_RED,    C_RED,   C_GREEN,  C_GREEN,  C_RED,    C_RED);
            PH_S8B:  r = mk(C_RED,    C_RED,    C_RED,   C_GREEN,  C_GREEN,  C_RED,    C_RED);
            PH_S9:   r = mk(C_YELLOW, C_RED,    C_RED,   C_YELLOW, C_GREEN,  C_RED,    C_RED);
            PH_S9B:  r = mk(C_RED,    C_RED,    C_RED,   C_YELLOW, C_GREEN,  C_RED,    C_RED);
            PH_S10:  r = mk(C_RED,    C_RED,    C_RED,   C_RED,    C_GREEN,  C_RED,    C_RED);
            PH_S11:  r = mk(C_RED,    C_RED,    C_GREEN, C_RED,    C_GREEN,  C_RED,    C_RED);
            PH_S12:  r = mk(C_RED,    C_RED,    C_YELLOW, C_RED,   C_YELLOW, C_RED,    C_RED);
            default: r = mk(C_RED,    C_RED,    C_RED,   C_RED,    C_RED,    C_RED,    C_RED);
        endcase
        return r;
    endfunction

endpackage

[design/traffic_light_phase_controller.sv]
// Top level of the 16-phase traffic light controller: phase and dwell state,
// result register and stream handshakes. Depends on tlpc_pkg, tlpc_cfg_regs
// and tlpc_step.
//
// Usage:
//   Input channel (s_): one item per timebase tick. s_tdata carries the seven
//   vehicle sensor levels, s_tuser the gate-down flag.
//   Result channel (m_): exactly one item per input item, holding the phase
//   after the tick, a flag telling whether the dwell expired and a step ran,
//   and the colours of signals one to seven.
//   Configuration: cfg_wr_en/cfg_addr/cfg_wdata write the green, yellow and
//   red dwell lengths (index 0, 1, 2); writes take effect at the next reload.
//   Result: registered, on m_ in the cycle after the item is accepted.
//   Throughput: one item per cycle while results are taken. The per-tick
//   work is a short decode of the phase register plus a 16-bit decrement,
//   both between the state registers and the result register.
//   Reset: phase goes to S1 (all red), dwell counter to 2, dwell registers
//   to 5/1/2; the result register is emptied.
//   Stall: while a result waits with m_tready low, s_tready drops and the
//   state holds; it rises in the cycle the result is taken.
module traffic_light_phase_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] sensor_levels, [7] zero
    input  logic        s_tuser,   // [0] gate_down
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] phase, [4] phase_changed,
                                   // [6:5] light_one .. [18:17] light_seven,
                                   // [23:19] zero
    // Configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    tlpc_pkg::dwell_cfg_t           dwell_cfg;
    tlpc_pkg::step_res_t            res;
    tlpc_pkg::phase_t               phase_reg;
    logic [tlpc_pkg::DWELL_W-1:0]   dwell_reg;
    logic                           m_valid_reg;
    logic [23:0]                    m_data_reg;
    logic                           s_fire;

    tlpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .dwell_cfg (dwell_cfg)
    );

    tlpc_step u_step (
        .phase         (phase_reg),
        .dwell_left    (dwell_reg),
        .sensor_levels (s_tdata[tlpc_pkg::SENSOR_W-1:0]),
        .gate_down     (s_tuser),
        .dwell_cfg     (dwell_cfg),
        .res           (res)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // Phase and dwell state advance once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tlpc_pkg::PH_S1;
            dwell_reg <= tlpc_pkg::RED_DWELL_RST;
        end else if (s_fire) begin
            phase_reg <= res.phase;
            dwell_reg <= res.dwell;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= {5'd0, res.colours, res.changed, res.phase};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[design/tlpc_cfg_regs.sv]
// Dwell length registers written through the plain configuration port.
// Depends on tlpc_pkg.
module tlpc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tlpc_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [tlpc_pkg::DWELL_W-1:0]     cfg_wdata,
    output tlpc_pkg::dwell_cfg_t             dwell_cfg
);

    tlpc_pkg::dwell_cfg_t cfg_reg;

    // Register writes; an unused index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.green  <= tlpc_pkg::GREEN_DWELL_RST;
            cfg_reg.yellow <= tlpc_pkg::YELLOW_DWELL_RST;
            cfg_reg.red    <= tlpc_pkg::RED_DWELL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tlpc_pkg::CFG_GREEN_DWELL:  cfg_reg.green  <= cfg_wdata;
                tlpc_pkg::CFG_YELLOW_DWELL: cfg_reg.yellow <= cfg_wdata;
                tlpc_pkg::CFG_RED_DWELL:    cfg_reg.red    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign dwell_cfg = cfg_reg;

endmodule

[design/tlpc_step.sv]
// One tick of the phase sequencer: dwell countdown, next-phase decode, reload
// and the colours of the resulting phase. Pure logic; depends on tlpc_pkg.
module tlpc_step (
    input  tlpc_pkg::phase_t                 phase,
    input  logic [tlpc_pkg::DWELL_W-1:0]     dwell_left,
    input  logic [tlpc_pkg::SENSOR_W-1:0]    sensor_levels,
    input  logic                             gate_down,
    input  tlpc_pkg::dwell_cfg_t             dwell_cfg,
    output tlpc_pkg::step_res_t              res
);

    logic                   expire;
    tlpc_pkg::phase_t       nxt;
    tlpc_pkg::dwell_sel_t   sel;
    logic [tlpc_pkg::DWELL_W-1:0] load;
    tlpc_pkg::phase_t       ph_out;

    // Dwell runs out when the count is at one (or zero)
    assign expire = (dwell_left[tlpc_pkg::DWELL_W-1:1] == '0);

    // Next phase and the dwell chosen by the phase being left
    always_comb begin
        nxt = phase;
        sel = tlpc_pkg::SEL_GREEN;
        unique case (phase)
            tlpc_pkg::PH_S1: begin
                if ((sensor_levels & tlpc_pkg::MASK_S1_GO) != '0) nxt = tlpc_pkg::PH_S2;
                sel = tlpc_pkg::SEL_RED;
            end
            tlpc_pkg::PH_S2: begin
                nxt = tlpc_pkg::PH_S3;
                sel = tlpc_pkg::SEL_GREEN;
            end
            tlpc_pkg::PH_S3: begin
                nxt = tlpc_pkg::PH_S4;
                sel = tlpc_pkg::SEL_YELLOW;
            end
            tlpc_pkg::PH_S4: begin
                nxt = gate_down ? tlpc_pkg::PH_S5B : tlpc_pkg::PH_S5;
                sel = tlpc_pkg::SEL_GREEN;
            end
            tlpc_pkg::PH_S5: begin
                if ((sensor_levels & tlpc_pkg::MASK_S5_GO) != '0) nxt = tlpc_pkg::PH_S6;
                sel = tlpc_pkg::SEL_GREEN;
            end
            tlpc_pkg::PH_S5B: begin
                if ((sensor_levels & tlpc_pkg::MASK_S5_GO) != '0) nxt = tlpc_pkg::PH_S6B;
                sel = tlpc_pkg::SEL_GREEN;
            end
            tlpc_pkg::PH_S6, tlpc_pkg::PH_S6B: begin
                nxt = tlpc_pkg::PH_S7;
                sel = tlpc_pkg::SEL_YELLOW;
            end
            tlpc_pkg::PH_S7: begin
                nxt = gate_down ? tlpc_pkg::PH_S8B : tlpc_pkg::PH_S8;
                sel = tlpc_pkg::SEL_RED;
            end
            tlpc_pkg::PH_S8: begin
                nxt = tlpc_pkg::PH_S9;
                sel = tlpc_pkg::SEL_GREEN;
            end
            tlpc_pkg::PH_S8B: begin
                nxt = tlpc_pkg::PH_S9B;
                sel = tlpc_pkg::SEL_GREEN;
            end
            tlpc_pkg::PH_S9: begin
                if ((sensor_levels & tlpc_pkg::MASK_S9_GO) != '0) nxt = tlpc_pkg::PH_S10;
                sel = tlpc_pkg::SEL_YELLOW;
            end
            tlpc_pkg::PH_S9B: begin
                if ((sensor_levels & tlpc_pkg::MASK_S9B_GO) != '0) nxt = tlpc_pkg::PH_S10;
                sel = tlpc_pkg::SEL_YELLOW;
            end
            tlpc_pkg::PH_S10: begin
                nxt = tlpc_pkg::PH_S11;
                sel = tlpc_pkg::SEL_GREEN;
            end
            tlpc_pkg::PH_S11: begin
                nxt = tlpc_pkg::PH_S12;
                sel = tlpc_pkg::SEL_GREEN;
            end
            tlpc_pkg::PH_S12: begin
                if ((sensor_levels & tlpc_pkg::MASK_S12_GO) != '0) nxt = tlpc_pkg::PH_S1;
                sel = tlpc_pkg::SEL_YELLOW;
            end
            default: begin
                nxt = phase;
                sel = tlpc_pkg::SEL_YELLOW;
            end
        endcase
    end

    // Reload value
    always_comb begin
        unique case (sel)
            tlpc_pkg::SEL_GREEN:  load = dwell_cfg.green;
            tlpc_pkg::SEL_YELLOW: load = dwell_cfg.yellow;
            default:              load = dwell_cfg.red;
        endcase
    end

    assign ph_out = expire ? nxt : phase;

    always_comb begin
        res.phase   = ph_out;
        res.dwell   = expire ? load : (dwell_left - 16'd1);
        res.changed = expire;
        res.colours = tlpc_pkg::phase_colours(ph_out);
    end

endmodule
